// File: rtl/tces_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tces_pkg: shared types and constants of the tone channel controller
// Operation codes, setting addresses, defaults and the queue entry type.
// ----------------------------------------------------------------------------
package tces_pkg;

   localparam int unsigned ChannelsDefault = 4;
   localparam int unsigned QueueDepth      = 2;

   localparam logic [15:0] Unity        = 16'd32768;
   localparam logic [31:0] NoiseFreq    = 32'd36291625;
   localparam logic [15:0] GainReset    = 16'd32768;
   localparam logic [31:0] FreqReset    = 32'd1802240;

   localparam logic [2:0] OpTick  = 3'd0;
   localparam logic [2:0] OpWrite = 3'd1;
   localparam logic [2:0] OpPlay  = 3'd2;
   localparam logic [2:0] OpStop  = 3'd3;
   localparam logic [2:0] OpInit  = 3'd4;

   localparam logic [2:0] AddrWave   = 3'd0;
   localparam logic [2:0] AddrGain   = 3'd1;
   localparam logic [2:0] AddrLength = 3'd2;
   localparam logic [2:0] AddrDecay  = 3'd3;
   localparam logic [2:0] AddrSweep  = 3'd4;
   localparam logic [2:0] AddrEnd    = 3'd5;
   localparam logic [2:0] AddrFreq   = 3'd6;

   localparam logic CsrDefaultGain = 1'b0;
   localparam logic CsrDefaultFreq = 1'b1;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  channel;
      logic [2:0]  reg_addr;
      logic [31:0] data;
      logic [31:0] now_ms;
   } cmd_type;

   function automatic logic [2:0] wave_default(input logic [1:0] ch);
      logic [2:0] w;
      w = 3'd0;
      if (ch == 2'd2) w = 3'd4;
      if (ch == 2'd3) w = 3'd5;
      return w;
   endfunction

   function automatic logic [15:0] clamp_gain(input logic [15:0] g);
      return (g > Unity) ? Unity : g;
   endfunction

endpackage

// File: rtl/tces_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tces_front: command intake and queue
// Drops commands that produce no items and queues the rest for the back end.
// ----------------------------------------------------------------------------
module tces_front
   import tces_pkg::*;
#(
   parameter int unsigned CHANNELS = ChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [2:0]  req_reg_addr,
   input  logic [31:0] req_data,
   input  logic [31:0] req_now_ms,
   output logic        q_valid,
   output cmd_type     q_cmd,
   input  logic        q_pop
);

   localparam int unsigned NumCh = (CHANNELS < 4) ? CHANNELS : 4;

   cmd_type    slot_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept, keep;

   assign busy   = (count_ff == 2'(QueueDepth));
   assign accept = start && !busy;
   // Only commands that yield items enter the queue.
   assign keep = (req_op == OpTick) || (req_op == OpInit) ||
      (((req_op == OpWrite) || (req_op == OpPlay) || (req_op == OpStop)) &&
       ({1'b0, req_channel} < 3'(NumCh)));

   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_pop && q_valid) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + 2'(accept && keep) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         slot_ff[wr_ptr_ff] <= '{op: req_op, channel: req_channel, reg_addr: req_reg_addr,
                                data: req_data, now_ms: req_now_ms};
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue overfilled");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !q_valid) else $error("empty queue shows valid");
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(QueueDepth)) |-> busy) else $error("full queue not busy");

endmodule

// File: rtl/tces_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tces_back: channel state and sequencer
// Executes one command, channel by channel, with one shared multiplier.
// ----------------------------------------------------------------------------
module tces_back
   import tces_pkg::*;
#(
   parameter int unsigned CHANNELS = ChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   output logic [1:0]  rsp_out_channel,
   output logic [15:0] rsp_gain,
   output logic [31:0] rsp_pitch,
   output logic [2:0]  rsp_waveform,
   output logic        rsp_playing,
   output logic        rsp_stopped_now,
   output logic        rsp_last
);

   localparam int unsigned NumCh = (CHANNELS < 4) ? CHANNELS : 4;
   localparam int unsigned ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_GAIN  = 5'b00010,
      S_FREQ  = 5'b00100,
      S_APPLY = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] def_gain_ff;
   logic [31:0] def_freq_ff;

   logic [15:0] cur_gain_ff   [CHANNELS];
   logic [15:0] start_gain_ff [CHANNELS];
   logic [31:0] cur_freq_ff   [CHANNELS];
   logic [31:0] start_freq_ff [CHANNELS];
   logic [31:0] end_freq_ff   [CHANNELS];
   logic [15:0] sweep_ff      [CHANNELS];
   logic [15:0] decay_ff      [CHANNELS];
   logic [31:0] length_ff     [CHANNELS];
   logic [31:0] start_ms_ff   [CHANNELS];
   logic [2:0]  wave_ff       [CHANNELS];
   logic [CHANNELS-1:0] play_ff;

   logic [47:0] prod_ff;
   logic        was_ff;
   logic [ChW-1:0] ci;
   logic [31:0]    mul_a;
   logic [15:0]    mul_b;
   logic           multi;

   assign ci    = ChW'(idx_ff);
   assign multi = (cmd_ff.op == OpTick) || (cmd_ff.op == OpInit);
   assign mul_a = (state_ff == S_GAIN) ? {16'd0, cur_gain_ff[ci]} : cur_freq_ff[ci];
   assign mul_b = (state_ff == S_GAIN) ? decay_ff[ci] : sweep_ff[ci];
   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_GAIN;
               idx_in   = ((q_cmd.op == OpTick) || (q_cmd.op == OpInit)) ? 2'd0 : q_cmd.channel;
            end
         end
         S_GAIN:  state_in = S_FREQ;
         S_FREQ:  state_in = S_APPLY;
         S_APPLY: state_in = S_EMIT;
         S_EMIT: begin
            if (multi && ({1'b0, idx_ff} != 3'(NumCh - 1))) begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_GAIN;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= 2'd0;
         def_gain_ff <= GainReset;
         def_freq_ff <= FreqReset;
         rsp_valid   <= 1'b0;
         play_ff     <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_gain_ff[i]   <= '0;
            start_gain_ff[i] <= '0;
            cur_freq_ff[i]   <= '0;
            start_freq_ff[i] <= '0;
            end_freq_ff[i]   <= '0;
            sweep_ff[i]      <= '0;
            decay_ff[i]      <= '0;
            length_ff[i]     <= '0;
            start_ms_ff[i]   <= '0;
            wave_ff[i]       <= wave_default(2'(i));
         end
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         rsp_valid <= 1'b0;
         if (csr_we) begin
            if (csr_index == CsrDefaultGain) def_gain_ff <= csr_wdata[15:0];
            if (csr_index == CsrDefaultFreq) def_freq_ff <= csr_wdata;
         end
         if (state_ff == S_GAIN) begin
            was_ff <= play_ff[ci];
         end
         // The gain product was registered during the gain cycle.
         if (state_ff == S_FREQ) begin
            if ((cmd_ff.op == OpTick) && (decay_ff[ci] != 16'd0) && (decay_ff[ci] < Unity))
               cur_gain_ff[ci] <= prod_ff[30:15];
         end
         if (state_ff == S_APPLY) begin
            case (cmd_ff.op)
               OpTick: begin
                  if ((length_ff[ci] != 32'd0) &&
                      ((cmd_ff.now_ms - start_ms_ff[ci]) >= length_ff[ci]))
                     play_ff[ci] <= 1'b0;
                  if (sweep_ff[ci] != 16'd0) begin
                     cur_freq_ff[ci] <= (prod_ff[47] != 1'b0) ? 32'hFFFF_FFFF : prod_ff[46:15];
                     if ((end_freq_ff[ci] != 32'd0) &&
                         (((sweep_ff[ci] > Unity) &&
                           (((prod_ff[47] != 1'b0) ? 32'hFFFF_FFFF : prod_ff[46:15])
                            >= end_freq_ff[ci])) ||
                          ((sweep_ff[ci] < Unity) &&
                           (((prod_ff[47] != 1'b0) ? 32'hFFFF_FFFF : prod_ff[46:15])
                            <= end_freq_ff[ci]))))
                        play_ff[ci] <= 1'b0;
                  end
               end
               OpInit: begin
                  cur_gain_ff[ci]   <= clamp_gain(def_gain_ff);
                  start_gain_ff[ci] <= clamp_gain(def_gain_ff);
                  cur_freq_ff[ci]   <= (idx_ff == 2'd3) ? NoiseFreq : def_freq_ff;
                  start_freq_ff[ci] <= (idx_ff == 2'd3) ? NoiseFreq : def_freq_ff;
                  wave_ff[ci]       <= wave_default(idx_ff);
               end
               OpWrite: begin
                  case (cmd_ff.reg_addr)
                     AddrWave: if (cmd_ff.data <= 32'd6) wave_ff[ci] <= cmd_ff.data[2:0];
                     AddrGain: begin
                        cur_gain_ff[ci]   <= clamp_gain(cmd_ff.data[15:0]);
                        start_gain_ff[ci] <= clamp_gain(cmd_ff.data[15:0]);
                     end
                     AddrLength: length_ff[ci] <= cmd_ff.data;
                     AddrDecay:  decay_ff[ci]  <= cmd_ff.data[15:0];
                     AddrSweep:  sweep_ff[ci]  <= cmd_ff.data[15:0];
                     AddrEnd:    end_freq_ff[ci] <= cmd_ff.data;
                     AddrFreq: begin
                        cur_freq_ff[ci]   <= cmd_ff.data;
                        start_freq_ff[ci] <= cmd_ff.data;
                     end
                     default: ;
                  endcase
               end
               OpPlay: begin
                  cur_gain_ff[ci] <= start_gain_ff[ci];
                  cur_freq_ff[ci] <= start_freq_ff[ci];
                  start_ms_ff[ci] <= cmd_ff.now_ms;
                  play_ff[ci]     <= 1'b1;
               end
               OpStop: play_ff[ci] <= 1'b0;
               default: ;
            endcase
         end
         if (state_ff == S_EMIT) begin
            rsp_valid <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_cmd;
      if ((state_ff == S_GAIN) || (state_ff == S_FREQ)) prod_ff <= mul_a * mul_b;
      if (state_ff == S_EMIT) begin
         rsp_out_channel <= idx_ff;
         rsp_gain        <= cur_gain_ff[ci];
         rsp_pitch       <= cur_freq_ff[ci];
         rsp_waveform    <= wave_ff[ci];
         rsp_playing     <= play_ff[ci];
         rsp_stopped_now <= was_ff && !play_ff[ci];
         rsp_last        <= !multi || ({1'b0, idx_ff} == 3'(NumCh - 1));
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_EMIT)) else $error("stray result");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_GAIN)) else $error("pop without start");

endmodule

// File: rtl/tone_channel_envelope_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_channel_envelope_sweep: four-channel tone controller
// Channel settings, play/stop/init and a millisecond tick with decay and sweep.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   request   start & !busy        req_op, req_channel, req_reg_addr, req_data, req_now_ms
//   result    rsp_valid (1 cycle)  rsp_out_channel, rsp_gain, rsp_pitch, rsp_waveform,
//                                  rsp_playing, rsp_stopped_now, rsp_last
//   config    csr_we               csr_index, csr_wdata
//
// Each reported channel passes through the back-end states gain, freq, apply
// and emit: the shared 32x16 multiplier computes the decayed gain and then the
// swept frequency, the state is updated, and the result is registered. A tick
// or init reports every channel in turn, other commands one; the back end takes
// the next command from the queue in its idle state. A two-entry queue lets the
// front accept while the back works; busy rises only when the queue is full.
// Reset is synchronous and restores all channel state. Results cannot be stalled.
// ----------------------------------------------------------------------------
module tone_channel_envelope_sweep
   import tces_pkg::*;
#(
   parameter int unsigned CHANNELS = ChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_channel,
   input  logic [2:0]  req_reg_addr,
   input  logic [31:0] req_data,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [1:0]  rsp_out_channel,
   output logic [15:0] rsp_gain,
   output logic [31:0] rsp_pitch,
   output logic [2:0]  rsp_waveform,
   output logic        rsp_playing,
   output logic        rsp_stopped_now,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic    q_valid, q_pop;
   cmd_type q_cmd;

   // The front filters commands that produce no items.
   tces_front #(.CHANNELS(CHANNELS)) u_front (
      .clock, .reset, .start, .busy,
      .req_op, .req_channel, .req_reg_addr, .req_data, .req_now_ms,
      .q_valid, .q_cmd, .q_pop
   );

   // The back holds all channel state and emits one item for each reported channel.
   tces_back #(.CHANNELS(CHANNELS)) u_back (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .q_valid, .q_cmd, .q_pop,
      .rsp_valid, .rsp_out_channel, .rsp_gain, .rsp_pitch, .rsp_waveform,
      .rsp_playing, .rsp_stopped_now, .rsp_last
   );

endmodule

// File: tb/tb_tone_channel_envelope_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_channel_envelope_sweep: self-checking bench of the tone controller
// A channel model in the bench predicts every report of each accepted command.
// Commands come in random bursts with gaps, and both default registers are
// swept through several settings between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_tone_channel_envelope_sweep;
   import tces_pkg::*;

   // One report of one channel, as the block puts it on the result ports.
   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] gain;
      logic [31:0] pitch;
      logic [2:0]  waveform;
      logic        playing;
      logic        stopped_now;
      logic        last;
   } tone_report_type;

   // Channel model and store of expected reports. Its state mirrors the
   // block's own: it is updated as each command is accepted, so the queue of
   // expected reports always runs ahead of the result port.
   class tone_channel_predictor;
      logic [15:0] cur_gain[4], start_gain[4], decay[4], sweep[4];
      logic [31:0] cur_freq[4], start_freq[4], end_freq[4], length_ms[4], start_ms[4];
      logic [2:0]  wave[4];
      logic        playing[4];
      logic [15:0] dflt_gain;
      logic [31:0] dflt_freq;
      tone_report_type expected_reports[$];
      int          errors;
      int          reports_checked;

      function new();
         for (int i = 0; i < 4; i++) begin
            cur_gain[i] = 0; start_gain[i] = 0; decay[i] = 0; sweep[i] = 0;
            cur_freq[i] = 0; start_freq[i] = 0; end_freq[i] = 0;
            length_ms[i] = 0; start_ms[i] = 0; playing[i] = 0;
            wave[i] = wave_for(i[1:0]);
         end
         dflt_gain = GainReset;
         dflt_freq = FreqReset;
         errors = 0;
         reports_checked = 0;
      endfunction

      function logic [2:0] wave_for(logic [1:0] ch);
         return (ch == 2'd2) ? 3'd4 : (ch == 2'd3) ? 3'd5 : 3'd0;
      endfunction

      function logic [15:0] limit_gain(logic [15:0] g);
         return (g > Unity) ? Unity : g;
      endfunction

      function void note_config(logic [0:0] idx, logic [31:0] value);
         if (idx == CsrDefaultGain) dflt_gain = value[15:0];
         else dflt_freq = value;
      endfunction

      function void push_report(int ch, logic was, logic last);
         tone_report_type r;
         r.channel = ch[1:0];
         r.gain = cur_gain[ch];
         r.pitch = cur_freq[ch];
         r.waveform = wave[ch];
         r.playing = playing[ch];
         r.stopped_now = was && !playing[ch];
         r.last = last;
         expected_reports.push_back(r);
      endfunction

      // Advances one channel by one tick, checking its length against now.
      function void tick_channel(int ch, logic [31:0] now);
         logic [63:0] prod;
         logic [31:0] elapsed;
         elapsed = now - start_ms[ch];
         if (length_ms[ch] != 0 && elapsed >= length_ms[ch]) playing[ch] = 0;
         if (decay[ch] != 0 && decay[ch] < Unity) begin
            prod = (64'(cur_gain[ch]) * 64'(decay[ch])) >> 15;
            cur_gain[ch] = prod[15:0];
         end
         if (sweep[ch] != 0) begin
            prod = (64'(cur_freq[ch]) * 64'(sweep[ch])) >> 15;
            cur_freq[ch] = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            if (end_freq[ch] != 0 &&
                ((sweep[ch] > Unity && cur_freq[ch] >= end_freq[ch]) ||
                 (sweep[ch] < Unity && cur_freq[ch] <= end_freq[ch])))
               playing[ch] = 0;
         end
      endfunction

      function void note_item(logic [2:0] op, logic [1:0] ch, logic [2:0] addr,
                              logic [31:0] data, logic [31:0] now);
         logic was;
         if (op == OpTick || op == OpInit) begin
            for (int i = 0; i < 4; i++) begin
               was = playing[i];
               if (op == OpTick) tick_channel(i, now);
               else begin
                  cur_gain[i] = limit_gain(dflt_gain);
                  start_gain[i] = cur_gain[i];
                  cur_freq[i] = (i == 3) ? NoiseFreq : dflt_freq;
                  start_freq[i] = cur_freq[i];
                  wave[i] = wave_for(i[1:0]);
               end
               push_report(i, was, i == 3);
            end
            return;
         end
         if (op > OpInit) return;
         was = playing[ch];
         case (op)
            OpWrite: begin
               case (addr)
                  AddrWave: if (data <= 32'd6) wave[ch] = data[2:0];
                  AddrGain: begin
                     cur_gain[ch] = limit_gain(data[15:0]);
                     start_gain[ch] = cur_gain[ch];
                  end
                  AddrLength: length_ms[ch] = data;
                  AddrDecay:  decay[ch] = data[15:0];
                  AddrSweep:  sweep[ch] = data[15:0];
                  AddrEnd:    end_freq[ch] = data;
                  AddrFreq: begin
                     cur_freq[ch] = data;
                     start_freq[ch] = data;
                  end
                  default: ;
               endcase
            end
            OpPlay: begin
               cur_gain[ch] = start_gain[ch];
               cur_freq[ch] = start_freq[ch];
               start_ms[ch] = now;
               playing[ch] = 1;
            end
            default: playing[ch] = 0;
         endcase
         push_report(ch, was, 1'b1);
      endfunction

      function void check_result(tone_report_type got);
         tone_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, channel %0d", $time, got.channel);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         reports_checked++;
         if (got.channel != want.channel)
            $display("%0t: channel exp %0d got %0d", $time, want.channel, got.channel);
         if (got.gain != want.gain)
            $display("%0t: gain exp %0d got %0d", $time, want.gain, got.gain);
         if (got.pitch != want.pitch)
            $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
         if (got.waveform != want.waveform)
            $display("%0t: waveform exp %0d got %0d", $time, want.waveform, got.waveform);
         if (got.playing != want.playing)
            $display("%0t: playing exp %0d got %0d", $time, want.playing, got.playing);
         if (got.stopped_now != want.stopped_now)
            $display("%0t: stopped_now exp %0d got %0d", $time,
                     want.stopped_now, got.stopped_now);
         if (got.last != want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
         if (got != want) errors++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [1:0]  req_channel = '0;
   logic [2:0]  req_reg_addr = '0;
   logic [31:0] req_data = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_out_channel;
   logic [15:0] rsp_gain;
   logic [31:0] rsp_pitch;
   logic [2:0]  rsp_waveform;
   logic        rsp_playing;
   logic        rsp_stopped_now;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tone_channel_predictor model = new();
   logic [31:0] ms_now = 32'd100;
   int          items_accepted = 0;
   int          burst_left = 0;
   int          stall_cycles = 0;

   localparam int DrainCycles = 40;     // a tick plus a queued tick, with margin
   localparam int WatchdogLimit = 3000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tone_channel_envelope_sweep dut (.*);

   // The result port cannot be held off, so every strobe is checked at once.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         model.check_result({rsp_out_channel, rsp_gain, rsp_pitch, rsp_waveform,
                             rsp_playing, rsp_stopped_now, rsp_last});
   end

   // Watchdog: any accepted command or report counts as progress.
   always @(posedge clock) begin
      if (reset || start && !busy || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("%0t: watchdog expired", $time);
         $display("tb_tone_channel_envelope_sweep NOT OK");
         $finish;
      end
   end

   // Presents one command at the falling edge and holds it until accepted.
   // Start stays high into the next command while a burst lasts; at the end
   // of a burst it drops for a random gap, sometimes none at all.
   task automatic send_cmd(logic [2:0] op, logic [1:0] ch, logic [2:0] addr,
                           logic [31:0] data, logic [31:0] now);
      int gap;
      @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_channel = ch;
      req_reg_addr = addr;
      req_data = data;
      req_now_ms = now;
      do @(posedge clock); while (busy);
      model.note_item(op, ch, addr, data, now);
      items_accepted++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic quiesce();
      @(negedge clock);
      start = 1'b0;
      while (model.expected_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      model.note_config(idx, value);
   endtask

   task automatic tick(int step);
      ms_now = ms_now + step;
      send_cmd(OpTick, 2'd0, 3'd0, $urandom, ms_now);
   endtask

   // Mostly well-formed note traffic: settings, plays and advancing ticks,
   // with a share of raw field noise and ignored codes.
   task automatic random_cmd();
      int pick;
      logic [1:0]  ch;
      logic [2:0]  addr;
      logic [31:0] data;
      pick = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      addr = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      data = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         case (addr)
            AddrWave:   data = $urandom_range(0, 8);
            AddrGain:   data = $urandom_range(0, 40000);
            AddrLength: data = $urandom_range(0, 20);
            AddrDecay:  data = $urandom_range(26000, 33000);
            AddrSweep:  data = $urandom_range(30000, 36000);
            AddrEnd:    data = $urandom_range(500000, 8000000);
            AddrFreq:   data = $urandom_range(500000, 8000000);
            default: ;
         endcase
      end
      if (pick < 32) begin
         if ($urandom_range(0, 19) == 0) ms_now = $urandom;
         tick($urandom_range(0, 4));
      end else if (pick < 62) send_cmd(OpWrite, ch, addr, data, $urandom);
      else if (pick < 76) send_cmd(OpPlay, ch, 3'($urandom), $urandom, ms_now);
      else if (pick < 85) send_cmd(OpStop, ch, 3'($urandom), $urandom, $urandom);
      else if (pick < 90) send_cmd(OpInit, ch, 3'($urandom), $urandom, $urandom);
      else if (pick < 95) send_cmd(3'($urandom_range(5, 7)), ch, addr, data, $urandom);
      else send_cmd(3'($urandom), ch, 3'($urandom), $urandom, $urandom);
   endtask

   initial begin
      int phase;
      int target;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reset defaults, field extremes, each command, the
      // ignored waveform code, the ignored setting address, ignored op codes,
      // a length running out, and a downward sweep crossing its end.
      tick(1);
      send_cmd(OpInit, 2'd0, 3'd0, 32'd0, 32'd0);
      send_cmd(OpWrite, 2'd0, AddrGain, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OpWrite, 2'd1, AddrGain, 32'd0, 32'd0);
      send_cmd(OpWrite, 2'd0, AddrWave, 32'd7, 32'd0);
      send_cmd(OpWrite, 2'd0, AddrWave, 32'hFFFF_FFF6, 32'd0);
      send_cmd(OpWrite, 2'd1, AddrWave, 32'd6, 32'd0);
      send_cmd(OpWrite, 2'd2, 3'd7, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OpWrite, 2'd0, AddrFreq, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OpWrite, 2'd0, AddrSweep, 32'hFFFF_FFFF, 32'd0);
      send_cmd(OpWrite, 2'd1, AddrDecay, 32'd1, 32'd0);
      send_cmd(OpWrite, 2'd2, AddrLength, 32'd2, 32'd0);
      send_cmd(OpWrite, 2'd3, AddrSweep, 32'd16384, 32'd0);
      send_cmd(OpWrite, 2'd3, AddrEnd, 32'd9000000, 32'd0);
      send_cmd(OpWrite, 2'd1, AddrSweep, 32'd40000, 32'd0);
      send_cmd(OpWrite, 2'd1, AddrEnd, 32'hFFFF_FFFF, 32'd0);
      for (int c = 0; c < 4; c++) send_cmd(OpPlay, c[1:0], 3'd0, 32'd0, ms_now);
      send_cmd(3'd5, 2'd0, 3'd0, 32'd0, 32'd0);
      send_cmd(3'd7, 2'd3, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      tick(1);
      tick(2);
      send_cmd(OpStop, 2'd0, 3'd0, 32'd0, 32'hFFFF_FFFF);
      ms_now = 32'hFFFF_FFFF;
      tick(0);

      // Random phases, each under its own default register setting.
      for (phase = 0; phase < 6; phase++) begin
         quiesce();
         case (phase)
            0: begin write_csr(CsrDefaultGain, 32'd0); write_csr(CsrDefaultFreq, 32'd0); end
            1: begin
               write_csr(CsrDefaultGain, 32'hFFFF_FFFF);
               write_csr(CsrDefaultFreq, 32'hFFFF_FFFF);
            end
            2: begin
               write_csr(CsrDefaultGain, 32'(Unity));
               write_csr(CsrDefaultFreq, FreqReset);
            end
            default: begin
               write_csr(CsrDefaultGain, $urandom);
               write_csr(CsrDefaultFreq, $urandom);
            end
         endcase
         target = items_accepted + 60;
         while (items_accepted < target) random_cmd();
      end

      quiesce();
      if (model.expected_reports.size() != 0) begin
         $display("%0t: %0d expected reports never arrived", $time,
                  model.expected_reports.size());
         model.errors++;
      end
      $display("Covered %0d commands and %0d channel reports over six register settings.",
               items_accepted, model.reports_checked);
      if (model.errors == 0) $display("tb_tone_channel_envelope_sweep OK");
      else $display("tb_tone_channel_envelope_sweep NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/tces_pkg.sv
rtl/tces_front.sv
rtl/tces_back.sv
rtl/tone_channel_envelope_sweep.sv
tb/tb_tone_channel_envelope_sweep.sv
